### sv/dsha_pkg.sv
// Shared types and constants for the dual sensor hysteresis alarm.
// Request/response payload structs, operation codes and register indexes.
// No dependencies.
package dsha_pkg;

   // Field widths
   localparam int SAMPLE_BITS      = 12;
   localparam int THRESH_BITS      = 12;
   localparam int TICKS_BITS       = 16;
   localparam int BLINK_COUNT_BITS = 16;
   localparam int FUNC_BITS        = 2;
   localparam int CSR_ADDR_BITS    = 2;
   localparam int CSR_DATA_BITS    = 16;

   // Width for threshold sums that must not wrap
   localparam int SUM_BITS = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 1;

   // Operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_TICK   = 2'd2;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_SMOKE_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_WATER_THRESHOLD = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_HYSTERESIS      = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BLINK_TICKS     = 2'd3;

   // Register reset values
   localparam logic [THRESH_BITS-1:0] SMOKE_THRESHOLD_RESET = 12'd2000;
   localparam logic [THRESH_BITS-1:0] WATER_THRESHOLD_RESET = 12'd1000;
   localparam logic [THRESH_BITS-1:0] HYSTERESIS_RESET      = 12'd100;
   localparam logic [TICKS_BITS-1:0]  BLINK_TICKS_RESET     = 16'd500;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [SAMPLE_BITS-1:0] smoke_sample;
      logic [SAMPLE_BITS-1:0] water_sample;
   } req_type;

   typedef struct packed {
      logic smoke_active;
      logic water_active;
      logic report_alarm;
      logic smoke_rise;
      logic water_rise;
      logic buzzer_drive;
      logic led_drive;
   } rsp_type;

endpackage

### sv/dual_sensor_hysteresis_alarm.sv
// Dual sensor hysteresis alarm: top level.
// Depends on dsha_pkg for payload types, operation codes and register indexes.
//
// Usage
//   Request channel (req_valid / req_stall / req_data) carries one operation:
//   a smoke/water sample pair, a clear or a blink tick. Every request gives
//   exactly one response on rsp_valid / rsp_stall / rsp_data with the alarm
//   flags, rising edges, buzzer latch and LED level after that request.
//   The response is registered: it shows from the cycle after the request is
//   accepted. Throughput is one request per cycle while the receiver does not
//   stall, set by the single state update stage; the response register is freed
//   in the same cycle it is taken, so requests stream back to back.
//   If the receiver stalls, the response holds in its register and req_stall
//   rises until it is taken; no request is lost.
//   The csr_ port writes thresholds, hysteresis and blink period; write only
//   while no request is in flight.
//   Synchronous reset clears all alarm state, restores register defaults and
//   empties the response register.
module dual_sensor_hysteresis_alarm #(
   parameter int BLINK_COUNT_BITS = dsha_pkg::BLINK_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dsha_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dsha_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [dsha_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [dsha_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int SB = dsha_pkg::SUM_BITS;
   // Compare width for the blink divider against the tick period
   localparam int LB = ((BLINK_COUNT_BITS > dsha_pkg::TICKS_BITS) ?
                        BLINK_COUNT_BITS : dsha_pkg::TICKS_BITS) + 1;

   // Configuration registers
   logic [dsha_pkg::THRESH_BITS-1:0] smoke_thr_ff;
   logic [dsha_pkg::THRESH_BITS-1:0] water_thr_ff;
   logic [dsha_pkg::THRESH_BITS-1:0] hyst_ff;
   logic [dsha_pkg::TICKS_BITS-1:0]  ticks_ff;

   // Alarm state
   logic                        smoke_flag_ff, smoke_flag_in;
   logic                        water_flag_ff, water_flag_in;
   logic                        buzzer_ff, buzzer_in;
   logic                        blink_en_ff, blink_en_in;
   logic                        led_ff, led_in;
   logic [BLINK_COUNT_BITS-1:0] count_ff, count_in;

   // Response register
   logic              rsp_valid_ff;
   dsha_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic smoke_rise, water_rise;
   logic [SB-1:0] smoke_ext, water_ext, smoke_thr_ext, water_thr_ext, hyst_ext;
   logic smoke_hit, water_hit;
   logic [LB-1:0] count_next, tick_limit;
   logic          count_wrap;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         smoke_thr_ff <= dsha_pkg::SMOKE_THRESHOLD_RESET;
         water_thr_ff <= dsha_pkg::WATER_THRESHOLD_RESET;
         hyst_ff      <= dsha_pkg::HYSTERESIS_RESET;
         ticks_ff     <= dsha_pkg::BLINK_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            dsha_pkg::REG_SMOKE_THRESHOLD:
               smoke_thr_ff <= csr_wdata[dsha_pkg::THRESH_BITS-1:0];
            dsha_pkg::REG_WATER_THRESHOLD:
               water_thr_ff <= csr_wdata[dsha_pkg::THRESH_BITS-1:0];
            dsha_pkg::REG_HYSTERESIS:
               hyst_ff <= csr_wdata[dsha_pkg::THRESH_BITS-1:0];
            dsha_pkg::REG_BLINK_TICKS:
               ticks_ff <= csr_wdata[dsha_pkg::TICKS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Widened operands so that threshold sums never wrap
   assign smoke_ext     = SB'(req_data.smoke_sample);
   assign water_ext     = SB'(req_data.water_sample);
   assign smoke_thr_ext = SB'(smoke_thr_ff);
   assign water_thr_ext = SB'(water_thr_ff);
   assign hyst_ext      = SB'(hyst_ff);

   // Smoke: sample > thr (idle) or sample > thr - hyst (alarmed, as sample + hyst > thr)
   assign smoke_hit = smoke_flag_ff ? ((smoke_ext + hyst_ext) > smoke_thr_ext)
                                    : (smoke_ext > smoke_thr_ext);

   // Water: nonzero and below thr, or below thr + hyst while alarmed
   assign water_hit   = (water_ext != '0) &&
                        (water_flag_ff ? (water_ext < (water_thr_ext + hyst_ext))
                                       : (water_ext < water_thr_ext));

   // Blink divider; a zero period acts as one
   assign count_next = LB'(count_ff) + LB'(1);
   assign tick_limit = (ticks_ff == '0) ? LB'(1) : LB'(ticks_ff);
   assign count_wrap = (count_next >= tick_limit) || (count_ff == '1);

   // State update for the accepted request
   always_comb begin
      smoke_flag_in = smoke_flag_ff;
      water_flag_in = water_flag_ff;
      buzzer_in     = buzzer_ff;
      blink_en_in   = blink_en_ff;
      led_in        = led_ff;
      count_in      = count_ff;
      smoke_rise    = 1'b0;
      water_rise    = 1'b0;
      case (req_data.func)
         dsha_pkg::FUNC_SAMPLE: begin
            smoke_flag_in = smoke_hit;
            water_flag_in = water_hit;
            // previous flag is the stored flag itself
            smoke_rise = smoke_hit && !smoke_flag_ff;
            water_rise = water_hit && !water_flag_ff;
            if (smoke_rise || water_rise) begin
               buzzer_in = 1'b1;
               if (!blink_en_ff) begin
                  blink_en_in = 1'b1;
                  led_in      = 1'b0;
                  count_in    = '0;
               end
            end
         end
         dsha_pkg::FUNC_CLEAR: begin
            smoke_flag_in = 1'b0;
            water_flag_in = 1'b0;
            buzzer_in     = 1'b0;
            blink_en_in   = 1'b0;
            led_in        = 1'b0;
            count_in      = '0;
         end
         dsha_pkg::FUNC_TICK: begin
            if (blink_en_ff) begin
               if (count_wrap) begin
                  count_in = '0;
                  led_in   = !led_ff;
               end else begin
                  count_in = count_next[BLINK_COUNT_BITS-1:0];
               end
            end
         end
         default: ;
      endcase

      rsp_data_in.smoke_active = smoke_flag_in;
      rsp_data_in.water_active = water_flag_in;
      rsp_data_in.report_alarm = smoke_flag_in || water_flag_in;
      rsp_data_in.smoke_rise   = smoke_rise;
      rsp_data_in.water_rise   = water_rise;
      rsp_data_in.buzzer_drive = buzzer_in;
      rsp_data_in.led_drive    = led_in;
   end

   // State and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         smoke_flag_ff <= 1'b0;
         water_flag_ff <= 1'b0;
         buzzer_ff     <= 1'b0;
         blink_en_ff   <= 1'b0;
         led_ff        <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            smoke_flag_ff <= smoke_flag_in;
            water_flag_ff <= water_flag_in;
            buzzer_ff     <= buzzer_in;
            blink_en_ff   <= blink_en_in;
            led_ff        <= led_in;
            count_ff      <= count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
